// ===== design/vbb_pkg.sv =====
// ----------------------------------------------------------------------------
// vbb_pkg: shared types and constants for the vertical box blur
// Field widths, configuration register indexes and the per-item tag that
// follows a pixel through the pipeline.
// ----------------------------------------------------------------------------
package vbb_pkg;

	localparam int PIXEL_W      = 8;
	localparam int OUT_ROW_W    = 14;
	localparam int OUT_COL_W    = 10;
	localparam int ROW_POS_W    = 15;
	localparam int CFG_LEN_W    = 11;
	localparam int CFG_CNT_W    = 14;
	localparam int CFG_DATA_W   = 14;
	localparam int CFG_INDEX_W  = 1;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_ROW_LENGTH = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT  = 1'd1;

	// Reset values of the configuration registers.
	localparam logic [CFG_LEN_W-1:0] ROW_LENGTH_RESET = 11'd1024;
	localparam logic [CFG_CNT_W-1:0] ROW_COUNT_RESET  = 14'd1024;

	// Input item kinds.
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_PAD   = 1'b1;

	// Information about the output pixel that an accepted item produces.
	typedef struct packed {
		logic                 produce;
		logic                 frame_end;
		logic [OUT_ROW_W-1:0] out_row;
		logic [OUT_COL_W-1:0] out_column;
	} item_tag_t;

endpackage

// ===== design/vbb_line_bank.sv =====
// ----------------------------------------------------------------------------
// vbb_line_bank: one row of the line store
// A single-port-write, single-port-read memory holding one stored image row,
// addressed by column, with registered read data.
// ----------------------------------------------------------------------------
module vbb_line_bank
	import vbb_pkg::*;
#(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10
) (
	input  logic               clk,
	input  logic               we,
	input  logic               re,
	input  logic [ADDR_W-1:0]  addr,
	input  logic [PIXEL_W-1:0] wdata,
	output logic [PIXEL_W-1:0] rdata
);

	logic [PIXEL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	// A read and a write to the same address in one cycle return the old value.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== design/vbb_position.sv =====
// ----------------------------------------------------------------------------
// vbb_position: raster position tracking
// Keeps the row, column and line store slot of the next item and decodes
// what that item does: the stored value, which rows join the window and
// which output pixel, if any, it produces.
// ----------------------------------------------------------------------------
module vbb_position
	import vbb_pkg::*;
#(
	parameter int RADIUS         = 4,
	parameter int MAX_ROW_LENGTH = 1024,
	parameter int WIN_ROWS       = 2 * RADIUS,
	parameter int COL_W          = $clog2(MAX_ROW_LENGTH),
	parameter int SLOT_W         = $clog2(WIN_ROWS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic                 cmd,
	input  logic [PIXEL_W-1:0]   pixel,
	input  logic [CFG_LEN_W-1:0] row_length,
	input  logic [CFG_CNT_W-1:0] row_count,
	output logic [COL_W-1:0]     column,
	output logic [SLOT_W-1:0]    slot,
	output logic [PIXEL_W-1:0]   cur,
	output logic [WIN_ROWS-1:0]  mask,
	output item_tag_t            tag
);

	localparam int LEN_W = $clog2(MAX_ROW_LENGTH + 1);
	localparam int CMP_W = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;
	localparam int K_W   = $clog2(WIN_ROWS + 1);

	logic [ROW_POS_W-1:0] row_q;
	logic [COL_W-1:0]     col_q;
	logic [SLOT_W-1:0]    slot_q;

	logic [CMP_W-1:0]     len_raw;
	logic [CMP_W-1:0]     eff_len;
	logic [CFG_CNT_W-1:0] eff_cnt;
	logic [ROW_POS_W-1:0] cnt_ext;
	logic [ROW_POS_W-1:0] row_end;
	logic [ROW_POS_W-1:0] row_next;
	logic [ROW_POS_W-1:0] orow;
	logic                 last_col;
	logic                 in_image;
	logic                 produce;

	assign len_raw = CMP_W'(row_length);

	always_comb begin
		if (len_raw == '0) begin
			eff_len = CMP_W'(1);
		end else if (len_raw > CMP_W'(MAX_ROW_LENGTH)) begin
			eff_len = CMP_W'(MAX_ROW_LENGTH);
		end else begin
			eff_len = len_raw;
		end
	end

	assign eff_cnt  = (row_count == '0) ? CFG_CNT_W'(1) : row_count;
	assign cnt_ext  = ROW_POS_W'(eff_cnt);
	assign row_end  = cnt_ext + ROW_POS_W'(RADIUS);
	assign row_next = row_q + ROW_POS_W'(1);
	assign last_col = (CMP_W'(col_q) + CMP_W'(1)) >= eff_len;
	assign in_image = row_q < cnt_ext;
	assign produce  = (row_q >= ROW_POS_W'(RADIUS)) && (row_q < row_end);
	assign orow     = row_q - ROW_POS_W'(RADIUS);

	assign column = col_q;
	assign slot   = slot_q;
	assign cur    = (cmd == CMD_PIXEL && in_image) ? pixel : '0;

	assign tag.produce    = produce;
	assign tag.frame_end  = produce && last_col && (orow == cnt_ext - ROW_POS_W'(1));
	assign tag.out_row    = orow[OUT_ROW_W-1:0];
	assign tag.out_column = OUT_COL_W'(col_q);

	// Bank b holds the row k rows above the current one; it joins the window
	// only when that row lies at or below the top of the image.
	for (genvar b = 0; b < WIN_ROWS; b++) begin : g_mask
		logic [K_W-1:0] row_age;
		assign row_age = (slot_q > SLOT_W'(b)) ? K_W'(slot_q - SLOT_W'(b))
			: K_W'(K_W'(slot_q) + K_W'(WIN_ROWS - b));
		assign mask[b] = row_q >= ROW_POS_W'(row_age);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			slot_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				if (row_next >= row_end) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= row_next;
					slot_q <= (slot_q == SLOT_W'(WIN_ROWS - 1)) ? '0
						: slot_q + SLOT_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

endmodule

// ===== design/vbb_average.sv =====
// ----------------------------------------------------------------------------
// vbb_average: window sum and division by the window size
// Adds the current sample to the stored rows at or below the image top, then
// divides by the window size through a constant reciprocal into the output
// register.
// ----------------------------------------------------------------------------
module vbb_average
	import vbb_pkg::*;
#(
	parameter int RADIUS   = 4,
	parameter int WIN_ROWS = 2 * RADIUS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              valid_s1,
	input  logic [PIXEL_W-1:0]                cur_s1,
	input  logic [WIN_ROWS-1:0]               mask_s1,
	input  item_tag_t                         tag_s1,
	input  logic [WIN_ROWS-1:0][PIXEL_W-1:0]  bank_data,
	output logic                              valid_q,
	output logic [PIXEL_W-1:0]                blurred_q,
	output item_tag_t                         tag_q
);

	localparam int WIN_SIZE  = WIN_ROWS + 1;
	localparam int SUM_W     = $clog2(WIN_SIZE * 255 + 1);
	localparam int DIV_SHIFT = SUM_W + 5;
	localparam int RECIP     = ((1 << DIV_SHIFT) + WIN_SIZE - 1) / WIN_SIZE;
	localparam int RECIP_W   = DIV_SHIFT;
	localparam int PROD_W    = SUM_W + RECIP_W;

	logic [SUM_W-1:0]  sum;
	logic [SUM_W-1:0]  sum_s2;
	logic              valid_s2;
	item_tag_t         tag_s2;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] quot;

	always_comb begin
		sum = SUM_W'(cur_s1);
		for (int b = 0; b < WIN_ROWS; b++) begin
			if (mask_s1[b]) begin
				sum = sum + SUM_W'(bank_data[b]);
			end
		end
	end

	// The rounded-up reciprocal is exact for every sum in range.
	assign prod = PROD_W'(sum_s2) * PROD_W'(RECIP_W'(RECIP));
	assign quot = prod >> DIV_SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
			valid_q  <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2    <= sum;
			tag_s2    <= tag_s1;
			blurred_q <= quot[PIXEL_W-1:0];
			tag_q     <= tag_s2;
		end
	end

endmodule

// ===== design/vertical_box_blur.sv =====
// ----------------------------------------------------------------------------
// vertical_box_blur: vertical box filter over a raster pixel stream
// An accepted pixel is registered with its bank reads, then as the window sum,
// then as the blurred result. Throughput: one pixel per cycle, set by the read
// and write of the line banks at accept time; a result left waiting on the master
// side holds the whole pipeline, and the slave side with it. Reset: asynchronous,
// active low; positions return to the top left and the registers to 1024 by 1024.
// ----------------------------------------------------------------------------
module vertical_box_blur
	import vbb_pkg::*;
#(
	parameter int RADIUS         = 4,
	parameter int MAX_ROW_LENGTH = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Slave side.
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,   // [7:0] pixel
	input  logic                   s_tuser,   // [0] cmd
	// Master side.
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [31:0]            m_tdata,   // [7:0] blurred, [21:8] out_row,
	                                          // [31:22] out_column
	output logic                   m_tlast,   // frame_end
	// Configuration write port.
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// The line store holds the last 2*RADIUS rows. Each stored row has a bank
	// of its own, so that one item reads every row of its window at the same
	// column at once while it overwrites the oldest row in its own bank.
	localparam int WIN_ROWS = 2 * RADIUS;
	localparam int COL_W    = $clog2(MAX_ROW_LENGTH);
	localparam int SLOT_W   = $clog2(WIN_ROWS);

	logic [CFG_LEN_W-1:0] row_length_q;
	logic [CFG_CNT_W-1:0] row_count_q;

	logic                 en;
	logic                 accept;

	logic [COL_W-1:0]     column;
	logic [SLOT_W-1:0]    slot;
	logic [PIXEL_W-1:0]   cur;
	logic [WIN_ROWS-1:0]  mask;
	item_tag_t            tag;

	logic                 valid_s1;
	logic [PIXEL_W-1:0]   cur_s1;
	logic [WIN_ROWS-1:0]  mask_s1;
	item_tag_t            tag_s1;

	logic [WIN_ROWS-1:0][PIXEL_W-1:0] bank_data;

	logic                 valid_q;
	logic [PIXEL_W-1:0]   blurred_q;
	item_tag_t            tag_q;

	// The whole pipeline moves together. It advances whenever the output
	// register is empty or its result is being taken. While a result waits
	// on the master side, every stage holds, bubbles included, and no new
	// pixel is accepted.
	assign en       = !valid_q || m_tready;
	assign s_tready = en;
	assign accept   = s_tvalid && en;

	// Configuration registers; the user writes them only while the block is idle (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= ROW_LENGTH_RESET;
			row_count_q  <= ROW_COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROW_LENGTH: row_length_q <= cfg_data[CFG_LEN_W-1:0];
				CFG_ROW_COUNT:  row_count_q  <= cfg_data[CFG_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	vbb_position #(
		.RADIUS         (RADIUS),
		.MAX_ROW_LENGTH (MAX_ROW_LENGTH),
		.WIN_ROWS       (WIN_ROWS),
		.COL_W          (COL_W),
		.SLOT_W         (SLOT_W)
	) u_position (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.cmd        (s_tuser),
		.pixel      (s_tdata),
		.row_length (row_length_q),
		.row_count  (row_count_q),
		.column     (column),
		.slot       (slot),
		.cur        (cur),
		.mask       (mask),
		.tag        (tag)
	);

	// Every bank is read at the current column when the pipeline advances;
	// only the bank of the current row is written, and only on acceptance.
	// Rows above the top of the image are masked off, so stale contents of a
	// bank are never summed.
	for (genvar b = 0; b < WIN_ROWS; b++) begin : g_bank
		vbb_line_bank #(
			.DEPTH  (MAX_ROW_LENGTH),
			.ADDR_W (COL_W)
		) u_bank (
			.clk   (clk),
			.we    (accept && (slot == SLOT_W'(b))),
			.re    (en),
			.addr  (column),
			.wdata (cur),
			.rdata (bank_data[b])
		);
	end

	// First stage: the decoded item alongside the bank read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept && tag.produce;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cur_s1  <= cur;
			mask_s1 <= mask;
			tag_s1  <= tag;
		end
	end

	vbb_average #(
		.RADIUS   (RADIUS),
		.WIN_ROWS (WIN_ROWS)
	) u_average (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_s1  (valid_s1),
		.cur_s1    (cur_s1),
		.mask_s1   (mask_s1),
		.tag_s1    (tag_s1),
		.bank_data (bank_data),
		.valid_q   (valid_q),
		.blurred_q (blurred_q),
		.tag_q     (tag_q)
	);

	assign m_tvalid = valid_q;
	assign m_tdata  = {tag_q.out_column, tag_q.out_row, blurred_q};
	assign m_tlast  = tag_q.frame_end;

endmodule
